// ===== rtl/color_sensor_cct_pipeline_unit_macros.svh =====
// Assertion macros for the color sensor CCT block.
`ifndef COLOR_SENSOR_CCT_PIPELINE_UNIT_MACROS_SVH
`define COLOR_SENSOR_CCT_PIPELINE_UNIT_MACROS_SVH
// implication checked on every clock, off during reset
`define CSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/csc_pkg.sv =====
// Shared types and constants for the color sensor CCT block.
package csc_pkg;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int AVERAGE_SHIFT_DEF = 2;
    localparam int CNT_W = 16;
    localparam int AVG_W = 24;
    localparam int CCT_W = 21;
    localparam int LUX_W = 18;
    localparam int OUT_W = 8 * ((CCT_W + LUX_W + 2 + 4 * CNT_W + 7) / 8);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SUM0 = 2'd1;
    localparam logic [1:0] ST_DEN0 = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_COMP, OP_AVG, OP_MAC, OP_SUM, OP_NUMDEN,
        OP_DIVINIT, OP_DIVSTEP, OP_DIVFIN, OP_HA, OP_HB, OP_HC, OP_FINAL
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic bail;
        logic div_done;
    } sts_t;
endpackage

// ===== rtl/csc_ctrl.sv =====
// Sequencer for the CCT datapath.
module csc_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  csc_pkg::sts_t  sts,
    input  logic           out_free,
    output csc_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           done
);
    import csc_pkg::*;
    `include "color_sensor_cct_pipeline_unit_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_COMP, S_AVG, S_MAC, S_SUM, S_ND, S_DINIT, S_DSTEP,
        S_DFIN, S_HA, S_HB, S_HC, S_FIN, S_WAIT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] idx_reg, idx_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd.op     = OP_NONE;
        cmd.idx    = idx_reg;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_LOAD;
                    state_next = S_COMP;
                end
            end
            S_COMP:
            begin
                cmd.op = OP_COMP;
                state_next = S_AVG;
                idx_next = 2'd0;
            end
            S_AVG:
            begin
                cmd.op = OP_AVG;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    state_next = S_MAC;
                    idx_next = 2'd0;
                end
            end
            S_MAC:
            begin
                // one matrix row of three products per cycle, row in idx
                cmd.op = OP_MAC;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd2)
                begin
                    state_next = S_SUM;
                    idx_next = 2'd0;
                end
            end
            S_SUM:
            begin
                cmd.op = OP_SUM;
                state_next = S_ND;
            end
            S_ND:
            begin
                cmd.op = OP_NUMDEN;
                state_next = sts.bail ? S_FIN : S_DINIT;
            end
            S_DINIT:
            begin
                cmd.op = OP_DIVINIT;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.op = OP_DIVSTEP;
                if (sts.div_done)
                    state_next = S_DFIN;
            end
            S_DFIN:
            begin
                cmd.op = OP_DIVFIN;
                state_next = S_HA;
            end
            S_HA:
            begin
                cmd.op = OP_HA;
                state_next = S_HB;
            end
            S_HB:
            begin
                cmd.op = OP_HB;
                state_next = S_HC;
            end
            S_HC:
            begin
                cmd.op = OP_HC;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.op = OP_FINAL;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    done = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    `CSC_ASSERT_IMP(a_done_wait, clk, rst_n, done, state_reg == S_WAIT, "done outside wait")
    `CSC_ASSERT_NEXT(a_start_go, clk, rst_n, (state_reg == S_IDLE) && start,
        state_reg == S_COMP, "start not taken")
    `CSC_ASSERT_NEXT(a_div_exit, clk, rst_n, (state_reg == S_DSTEP) && sts.div_done,
        state_reg == S_DFIN, "divider exit missed")
endmodule

// ===== rtl/csc_datapath.sv =====
// Arithmetic datapath: compensation, averages, XYZ, divider and cubic.
module csc_datapath
#(
    parameter int SAMPLE_BITS   = csc_pkg::SAMPLE_BITS_DEF,
    parameter int AVERAGE_SHIFT = csc_pkg::AVERAGE_SHIFT_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  csc_pkg::cmd_t                cmd,
    input  logic                         comp_en,
    input  logic [4*csc_pkg::CNT_W-1:0]  in_data,
    output csc_pkg::sts_t                sts,
    output logic [csc_pkg::OUT_W-1:0]    result
);
    import csc_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] SMAX = {SAMPLE_BITS{1'b1}};
    localparam int DEN_W = 58;

    logic [SAMPLE_BITS-1:0] v_reg [4];
    logic [AVG_W-1:0]       avg_reg [4];
    logic signed [41:0]     tri_reg [3];
    logic signed [41:0]     sum_reg;
    logic                   neg_reg;
    logic                   ov_reg;
    logic [DEN_W-1:0]       an_reg, ad_reg, r_reg;
    logic [21:0]            q_reg;
    logic [4:0]             cnt_reg;
    logic signed [23:0]     n_reg;
    logic signed [63:0]     h_reg;
    logic [1:0]             status_reg;
    logic signed [CCT_W-1:0] cct_reg;

    // Q16 matrix, rows X,Y,Z over r,g,b
    function automatic logic signed [17:0] coef(input logic [1:0] r, input logic [1:0] c);
        logic signed [17:0] k;
        case ({r, c})
            4'h0: k = -18'sd9360;
            4'h1: k = 18'sd101531;
            4'h2: k = -18'sd62679;
            4'h4: k = -18'sd21277;
            4'h5: k = 18'sd103440;
            4'h6: k = -18'sd47966;
            4'h8: k = -18'sd44697;
            4'h9: k = 18'sd50511;
            4'hA: k = 18'sd36918;
            default: k = 18'sd0;
        endcase
        return k;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] sat(input logic [SAMPLE_BITS+1:0] x);
        return (x > {2'b00, SMAX}) ? SMAX : x[SAMPLE_BITS-1:0];
    endfunction

    // compensation
    logic [SAMPLE_BITS+4:0]  g_mul;
    logic [SAMPLE_BITS+16:0] b_mul;
    assign g_mul = {5'd0, v_reg[2]} * (SAMPLE_BITS+5)'(21);
    assign b_mul = {17'd0, v_reg[3]} * (SAMPLE_BITS+17)'(104681);

    // average update
    logic [AVG_W+AVERAGE_SHIFT-1:0] acc;
    assign acc = {{AVERAGE_SHIFT{1'b0}}, avg_reg[cmd.idx]} * (AVG_W+AVERAGE_SHIFT)'((1 << AVERAGE_SHIFT) - 1)
               + (AVG_W+AVERAGE_SHIFT)'({v_reg[cmd.idx], 8'd0});

    // one row of three products per cycle
    logic signed [41:0] row;
    assign row = coef(cmd.idx, 2'd0) * $signed({1'b0, v_reg[1]})
               + coef(cmd.idx, 2'd1) * $signed({1'b0, v_reg[2]})
               + coef(cmd.idx, 2'd2) * $signed({1'b0, v_reg[3]});

    logic signed [DEN_W-1:0] num_s, den_s;
    assign num_s = (DEN_W'(tri_reg[0]) <<< 16) - DEN_W'(sum_reg) * DEN_W'(21758);
    assign den_s = DEN_W'(sum_reg) * DEN_W'(12177) - (DEN_W'(tri_reg[1]) <<< 16);

    // restoring divider, one quotient bit a cycle, 6 integer + 16 fraction bits
    logic [DEN_W-1:0] r_sh, r_sub;
    logic             r_ge;
    assign r_sh  = {r_reg[DEN_W-2:0], an_reg[DEN_W-1]};
    assign r_ge  = r_sh >= ad_reg;
    assign r_sub = r_ge ? r_sh - ad_reg : r_sh;

    // multiplier operand is a or b, both within 40 bits
    logic signed [39:0] h_op;
    logic signed [63:0] hprod;
    logic signed [63:0] hfl;
    assign h_op  = h_reg[39:0];
    assign hprod = 64'(h_op) * 64'(n_reg);
    assign hfl   = hprod >>> 16;

    logic signed [63:0] cct_t;
    assign cct_t = (h_reg < 0) ? -((-h_reg) >>> 16) : (h_reg >>> 16);

    assign sts.bail     = (sum_reg == 42'sd0) || (den_s == '0);
    assign sts.div_done = (cnt_reg == 5'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                avg_reg[i] <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_AVG:
                    avg_reg[cmd.idx] <= acc[AVERAGE_SHIFT +: AVG_W];
                default:
                begin
                end
            endcase
            if (cmd.op == OP_DIVSTEP || cmd.op == OP_DIVINIT)
                cnt_reg <= (cmd.op == OP_DIVINIT) ? 5'd21 : cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
                for (int i = 0; i < 4; i++)
                    v_reg[i] <= in_data[i*CNT_W +: SAMPLE_BITS];
            OP_COMP:
                if (comp_en)
                begin
                    v_reg[2] <= sat((SAMPLE_BITS+2)'(g_mul >> 4));
                    v_reg[3] <= sat({1'b0, b_mul[SAMPLE_BITS+16:16]});
                end
            OP_MAC:
                tri_reg[cmd.idx] <= row;
            OP_SUM:
                sum_reg <= tri_reg[0] + tri_reg[1] + tri_reg[2];
            OP_NUMDEN:
            begin
                neg_reg <= num_s[DEN_W-1] ^ den_s[DEN_W-1];
                an_reg  <= num_s[DEN_W-1] ? -num_s : num_s;
                ad_reg  <= den_s[DEN_W-1] ? -den_s : den_s;
                status_reg <= (sum_reg == 42'sd0) ? ST_SUM0 :
                              (den_s == '0) ? ST_DEN0 : ST_OK;
                cct_reg <= '0;
            end
            OP_DIVINIT:
            begin
                // |num| >> 6 seeds the remainder; its low 6 bits, then 16 zeros, follow
                r_reg  <= an_reg >> 6;
                an_reg <= {an_reg[5:0], {(DEN_W-6){1'b0}}};
                ov_reg <= (an_reg >> 6) >= ad_reg;
                q_reg  <= '0;
            end
            OP_DIVSTEP:
            begin
                r_reg  <= r_sub;
                an_reg <= {an_reg[DEN_W-2:0], 1'b0};
                q_reg  <= {q_reg[20:0], r_ge};
            end
            OP_DIVFIN:
            begin
                if (ov_reg)
                    n_reg <= neg_reg ? -24'sd4194304 : 24'sd4194304;
                else
                    n_reg <= neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
            end
            OP_HA:
                h_reg <= 64'(n_reg) * 64'sd449 + 64'sd231014400;
            OP_HB:
                h_reg <= hfl + 64'sd447171789;
            OP_HC:
                h_reg <= hfl + 64'sd361780347;
            OP_FINAL:
                if (status_reg == ST_OK)
                begin
                    if (cct_t > 64'sd1048575)
                    begin
                        cct_reg <= 21'sd1048575;
                        status_reg <= ST_SAT;
                    end
                    else if (cct_t < -64'sd1048576)
                    begin
                        cct_reg <= -21'sd1048576;
                        status_reg <= ST_SAT;
                    end
                    else
                        cct_reg <= cct_t[CCT_W-1:0];
                end
            default:
            begin
            end
        endcase
    end

    logic signed [41:0] y_t;
    assign y_t = (tri_reg[1] < 0) ? -((-tri_reg[1]) >>> 16) : (tri_reg[1] >>> 16);

    assign result = OUT_W'({
        16'(avg_reg[3] >> 8), 16'(avg_reg[2] >> 8),
        16'(avg_reg[1] >> 8), 16'(avg_reg[0] >> 8),
        status_reg, y_t[LUX_W-1:0], cct_reg});
endmodule

// ===== rtl/color_sensor_cct_pipeline_unit.sv =====
// When the sum or the denominator is zero, the divider and cubic steps are skipped.
// One reading in flight at a time; a new word is accepted only while the sequencer is idle.
// The divider is bit-serial (22 steps), and the cubic's HB and HC steps share one multiplier.
// The output register frees the datapath; a finished result waits for it to drain.
// rst_n (async, low) clears averages, compensation enable and control state.
module color_sensor_cct_pipeline_unit
#(
    parameter int SAMPLE_BITS   = csc_pkg::SAMPLE_BITS_DEF,
    parameter int AVERAGE_SHIFT = csc_pkg::AVERAGE_SHIFT_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // clear_count, red_count, green_count, blue_count
    input  logic [4*csc_pkg::CNT_W-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // cct_kelvin, illuminance, status, average_clear/red/green/blue, zero pad
    output logic [csc_pkg::OUT_W-1:0]   m_axis_tdata
);
    import csc_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic busy, done, comp_reg;
    logic [OUT_W-1:0] res;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_reg      <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                comp_reg <= cfg_data;
            if (done)
                m_axis_tvalid <= 1'b1;
            else if (m_axis_tready)
                m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
            m_axis_tdata <= res;
    end

    csc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(s_axis_tvalid), .sts(sts),
        .out_free(!m_axis_tvalid || m_axis_tready),
        .cmd(cmd), .busy(busy), .done(done)
    );

    csc_datapath #(.SAMPLE_BITS(SAMPLE_BITS), .AVERAGE_SHIFT(AVERAGE_SHIFT)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .comp_en(comp_reg),
        .in_data(s_axis_tdata), .sts(sts), .result(res)
    );
endmodule
